### design/assert_macros.svh
// Assertion macros used by the port-level checker of the project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, disabled while reset is asserted.
`define PLD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("polyline decimator assertion failed");

// Concurrent assertion sampled on clk that also holds during reset.
`define PLD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("polyline decimator assertion failed in reset");

`endif

### design/pld_pkg.sv
// Shared types and constants of the polyline distance decimator.
// Depends on nothing; imported by the decimator modules.
package pld_pkg;

	localparam int COORD_W   = 32;
	localparam int SPACING_W = 16;
	localparam int OQ_DEPTH  = 4;
	localparam int OQ_AW     = $clog2(OQ_DEPTH);
	localparam int OQ_CW     = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic   run_end;
		point_t pt;
	} out_item_t;

	// up to two result items written into the output queue in one cycle
	typedef struct packed {
		logic      v0;
		out_item_t i0;
		logic      v1;
		out_item_t i1;
	} push_t;

	typedef struct packed {
		logic room2;
		logic empty;
	} oq_stat_t;

endpackage

### design/polyline_distance_decimator.sv
// Top level of the radial distance polyline decimator.
// Depends on pld_pkg, pld_dist and pld_oq.
//
// Points of a polyline stream in one per item; the first point is kept and a
// later point is kept when its distance from the last kept point plus one half
// reaches min_spacing (exact squared-distance compare, no root). Kept points
// are held back by one so the close of a run can be settled at the point that
// carries tlast: a polyline whose only kept point is the first one closes with
// the first and the final point, otherwise the last kept point closes the run
// and the final point itself is dropped. A lone point marked final comes out
// twice. The block takes one item per cycle while its output queue has room:
// each accepted point sits in an input register, where one pass of three
// 33x33 squarers, an add and a compare decides it against the anchor, and
// its results (zero, one or two items) go into a four-entry output queue.
// The input stalls only when that queue has fewer than two free entries.
// min_spacing may be written only while idle; its threshold is precomputed
// at the write.
module polyline_distance_decimator import pld_pkg::*; #(
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel: min_spacing
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// input points
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
	input  logic        s_axis_tlast,   // final_point
	// kept points
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
	output logic        m_axis_tlast    // run_end
);

	localparam int T_W   = SPACING_W + 1;
	localparam int TSQ_W = 2 * T_W;
	localparam int THR_W = TSQ_W + 2 * COORD_FRAC_BITS;

	// threshold ((2s - 1)^2 << 2F), prepared when min_spacing is written
	logic [THR_W-1:0] thr_q;
	logic             keep_all_q;
	logic [T_W-1:0]   t_val;
	logic [TSQ_W-1:0] t_sq;

	// input stage
	logic   valid_s1;
	point_t pt_s1;
	logic   fin_s1;

	// run state; the held point and the anchor are always the same point
	point_t anchor_q;
	logic   first_seen_q;
	logic   kept_q;

	logic      far;
	logic      fire;
	push_t     push;
	out_item_t head;
	oq_stat_t  oq_stat;

	assign cfg_ready = 1'b1;
	assign t_val     = {cfg_data, 1'b0} - T_W'(1);
	assign t_sq      = TSQ_W'(t_val) * TSQ_W'(t_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= '0;
			keep_all_q <= 1'b1;
		end else if (cfg_valid) begin
			thr_q      <= THR_W'(t_sq) << (2 * COORD_FRAC_BITS);
			keep_all_q <= (cfg_data == '0);
		end
	end

	// advance the input stage when it is empty or its item is processed now
	assign fire          = valid_s1 && oq_stat.room2;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pt_s1  <= point_t'(s_axis_tdata);
			fin_s1 <= s_axis_tlast;
		end
	end

	pld_dist #(
		.THR_W(THR_W)
	) u_dist (
		.pt       (pt_s1),
		.anchor   (anchor_q),
		.thr      (thr_q),
		.keep_all (keep_all_q),
		.far      (far)
	);

	// decide which items this point releases
	always_comb begin
		push            = '0;
		push.i0.pt      = first_seen_q ? anchor_q : pt_s1;
		push.i0.run_end = 1'b0;
		push.i1.pt      = pt_s1;
		push.i1.run_end = 1'b1;
		if (fire) begin
			if (!first_seen_q) begin
				// lone point marked final: emit it twice
				push.v0 = fin_s1;
				push.v1 = fin_s1;
			end else if (fin_s1) begin
				push.v0 = 1'b1;
				if (far || kept_q) begin
					push.i0.run_end = 1'b1;
				end else begin
					push.v1 = 1'b1;
				end
			end else begin
				push.v0 = far;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q     <= '0;
			first_seen_q <= 1'b0;
			kept_q       <= 1'b0;
		end else if (fire) begin
			if (!first_seen_q) begin
				anchor_q     <= pt_s1;
				first_seen_q <= !fin_s1;
				kept_q       <= 1'b0;
			end else if (fin_s1) begin
				// close the run; the next point starts a new polyline
				first_seen_q <= 1'b0;
				kept_q       <= 1'b0;
			end else if (far) begin
				anchor_q <= pt_s1;
				kept_q   <= 1'b1;
			end
		end
	end

	pld_oq u_oq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (m_axis_tready),
		.head   (head),
		.stat   (oq_stat)
	);

	assign m_axis_tvalid = !oq_stat.empty;
	assign m_axis_tdata  = 96'(head.pt);
	assign m_axis_tlast  = head.run_end;

endmodule

### design/pld_dist.sv
// Squared distance test between a point and the anchor point.
// Depends on pld_pkg.
module pld_dist import pld_pkg::*; #(
	parameter int THR_W = 50
) (
	input  point_t           pt,
	input  point_t           anchor,
	input  logic [THR_W-1:0] thr,
	input  logic             keep_all,
	output logic             far
);

	localparam int DW    = COORD_W + 1;
	localparam int SQ_W  = 2 * DW;
	localparam int SUM_W = SQ_W + 2;
	localparam int LHS_W = SUM_W + 2;
	localparam int CMP_W = (THR_W > LHS_W) ? THR_W : LHS_W;

	logic signed [DW-1:0] dx, dy, dz;
	logic [DW-1:0]        mx, my, mz;
	logic [SQ_W-1:0]      sx, sy, sz;
	logic [SUM_W-1:0]     sum;
	logic [CMP_W-1:0]     lhs, rhs;

	always_comb begin
		dx  = $signed({pt.x[COORD_W-1], pt.x}) - $signed({anchor.x[COORD_W-1], anchor.x});
		dy  = $signed({pt.y[COORD_W-1], pt.y}) - $signed({anchor.y[COORD_W-1], anchor.y});
		dz  = $signed({pt.z[COORD_W-1], pt.z}) - $signed({anchor.z[COORD_W-1], anchor.z});
		mx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
		my  = dy[DW-1] ? DW'(-dy) : DW'(dy);
		mz  = dz[DW-1] ? DW'(-dz) : DW'(dz);
		sx  = SQ_W'(mx) * SQ_W'(mx);
		sy  = SQ_W'(my) * SQ_W'(my);
		sz  = SQ_W'(mz) * SQ_W'(mz);
		sum = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);
		// four times the squared distance against (2s - 1)^2 scaled
		lhs = CMP_W'({sum, 2'b00});
		rhs = CMP_W'(thr);
		far = keep_all || (lhs >= rhs);
	end

endmodule

### design/pld_oq.sv
// Output queue of the decimator: takes up to two items per cycle, gives one.
// Depends on pld_pkg.
module pld_oq import pld_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	input  logic      pop,
	output out_item_t head,
	output oq_stat_t  stat
);

	out_item_t        mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [OQ_CW-1:0] count_q;
	logic             do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign wr_ptr_nx = wr_ptr_q + OQ_AW'(1);
	assign head      = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.room2 = (count_q <= OQ_CW'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.i0;
		end
		if (push.v1) begin
			mem_q[wr_ptr_nx] <= push.i1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(push.v0) + OQ_AW'(push.v1);
			rd_ptr_q <= rd_ptr_q + OQ_AW'(do_pop);
			count_q  <= count_q + OQ_CW'(push.v0) + OQ_CW'(push.v1) - OQ_CW'(do_pop);
		end
	end

endmodule

### design/pld_checker.sv
// Port-level checks of the polyline distance decimator, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [15:0] cfg_data,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [95:0] s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	// hold a stalled result item
	`PLD_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// no result item in the cycle after reset is seen at a clock edge
	`PLD_ASSERT_ALWAYS(a_out_reset, clk, !arst_n |=> !m_axis_tvalid)

	// an empty queue fills only from an accepted point that has passed the input register
	`PLD_ASSERT(a_out_cause, clk, arst_n, $rose(m_axis_tvalid) |-> $past(in_acc, 2))

	// the configuration port never stalls
	`PLD_ASSERT(a_cfg_ready, clk, arst_n, cfg_valid |-> cfg_ready)

endmodule

bind polyline_distance_decimator pld_checker u_pld_checker (.*);

### bench/pld_stream_checker.sv
`timescale 1ns / 100ps
// Stream checker for the polyline distance decimator: watches the config, input and output
// channels, predicts the kept points and compares them. Depends on pld_pkg.
module pld_stream_checker import pld_pkg::*; #(
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [95:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          pending
);

	logic [15:0] spacing_shadow;
	point_t      anchor_pt;
	point_t      held_pt;
	bit          run_open;
	bit          kept_past_first;
	out_item_t   kept_points_due[$];

	function automatic logic [127:0] axis_sq(logic signed [31:0] u, logic signed [31:0] v);
		longint      d;
		logic [127:0] m;
		d = longint'(u) - longint'(v);
		m = 128'((d < 0) ? -d : d);
		return m * m;
	endfunction

	// exact test: 4 * |p - a|^2 >= (2 * spacing - 1)^2 scaled to raw units
	function automatic bit far_from_anchor(point_t p, point_t a, logic [15:0] sp);
		logic [127:0] dist4;
		logic [127:0] bound;
		logic [127:0] t;
		if (sp == 16'd0)
			return 1'b1;
		dist4 = (axis_sq(p.x, a.x) + axis_sq(p.y, a.y) + axis_sq(p.z, a.z)) << 2;
		t     = 128'(sp) * 2 - 1;
		bound = (t * t) << (2 * COORD_FRAC_BITS);
		return dist4 >= bound;
	endfunction

	function automatic out_item_t make_item(point_t p, bit last);
		out_item_t it;
		it.pt      = p;
		it.run_end = last;
		return it;
	endfunction

	task automatic predict_kept_points(point_t p, bit fin);
		bit kept;
		if (!run_open) begin
			anchor_pt       = p;
			held_pt         = p;
			run_open        = 1'b1;
			kept_past_first = 1'b0;
			if (fin) begin
				kept_points_due.push_back(make_item(p, 1'b0));
				kept_points_due.push_back(make_item(p, 1'b1));
				run_open = 1'b0;
			end
		end else begin
			kept = far_from_anchor(p, anchor_pt, spacing_shadow);
			if (fin) begin
				if (kept || kept_past_first) begin
					kept_points_due.push_back(make_item(held_pt, 1'b1));
				end else begin
					kept_points_due.push_back(make_item(held_pt, 1'b0));
					kept_points_due.push_back(make_item(p, 1'b1));
				end
				run_open        = 1'b0;
				kept_past_first = 1'b0;
			end else if (kept) begin
				kept_points_due.push_back(make_item(held_pt, 1'b0));
				held_pt         = p;
				anchor_pt       = p;
				kept_past_first = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t got;
		out_item_t want;
		if (!arst_n) begin
			spacing_shadow  = '0;
			anchor_pt       = '0;
			held_pt         = '0;
			run_open        = 1'b0;
			kept_past_first = 1'b0;
			kept_points_due.delete();
			mismatches      = 0;
			pending         = 0;
		end else begin
			// results first: a result never comes from a point accepted at this same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got.pt      = point_t'(m_axis_tdata);
				got.run_end = m_axis_tlast;
				if (kept_points_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t unexpected item x=%0d y=%0d z=%0d run_end=%0b", $realtime,
							got.pt.x, got.pt.y, got.pt.z, got.run_end);
				end else begin
					want = kept_points_due.pop_front();
					if (got.pt.x !== want.pt.x || got.pt.y !== want.pt.y ||
					    got.pt.z !== want.pt.z || got.run_end !== want.run_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t mismatch: expected x=%0d y=%0d z=%0d run_end=%0b, %s",
								$realtime, want.pt.x, want.pt.y, want.pt.z, want.run_end,
								$sformatf("got x=%0d y=%0d z=%0d run_end=%0b",
									got.pt.x, got.pt.y, got.pt.z, got.run_end));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_kept_points(point_t'(s_axis_tdata), s_axis_tlast);
			if (cfg_valid && cfg_ready)
				spacing_shadow = cfg_data;
			pending = kept_points_due.size();
		end
	end

endmodule

### bench/polyline_distance_decimator_test.sv
`timescale 1ns / 100ps
// Top of the polyline distance decimator testbench: clock, reset, stimulus and verdict.
// Depends on pld_pkg, polyline_distance_decimator and pld_stream_checker.
module polyline_distance_decimator_test;
	import pld_pkg::*;

	localparam int IDLE_LIMIT  = 5000;  // cycles without any handshake before giving up
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int SETTLE      = 6;     // cycles to let an item without results retire

	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tlast;

	int mismatches;
	int pending;
	int burst_left   = 0;
	int holds_asked  = 0;
	int holds_served = 0;
	int idle_cycles  = 0;

	always #2 clk = ~clk;

	polyline_distance_decimator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	pld_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// Watchdog: count cycles with no handshake on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("[polyline_distance_decimator] ERROR");
				$finish;
			end
		end
	end

	// Receiver: stall on a pattern of its own, switching between always ready,
	// random stalls and a regular duty cycle; serve long hold-offs on request.
	initial begin
		int mode;
		int span;
		int tick;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(negedge clk);
				if (holds_served != holds_asked) begin
					// hold off long enough for the output queue to fill and stall the input
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					holds_served++;
				end
				tick++;
				case (mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						m_axis_tready <= (tick % 5 < 2);
					end
				endcase
			end
		end
	end

	function automatic point_t make_pt(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	function automatic point_t random_pt();
		return make_pt($urandom, $urandom, $urandom);
	endfunction

	// Step each axis by up to +/- lim raw units; coordinates wrap at 32 bits.
	function automatic point_t walk_pt(point_t from, int lim);
		point_t p;
		p.x = from.x + (int'($urandom_range(0, 2 * lim)) - lim);
		p.y = from.y + (int'($urandom_range(0, 2 * lim)) - lim);
		p.z = from.z + (int'($urandom_range(0, 2 * lim)) - lim);
		return p;
	endfunction

	// Offer one point and hold it until accepted. Gaps fall between bursts;
	// tvalid stays high from one item to the next within a burst.
	task automatic send_point(point_t p, bit fin);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= p;
		s_axis_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		burst_left--;
	endtask

	// Drop tvalid and wait until every expected result has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_spacing(logic [15:0] sp);
		cfg_valid <= 1'b1;
		cfg_data  <= sp;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random polylines: mostly random walks scaled to the spacing so points are
	// both kept and skipped, with some tiny steps and some wild jumps.
	task automatic run_random_phase(int n_items, logic [15:0] sp);
		int     sent;
		int     len;
		int     lim;
		int     k;
		point_t cur;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 14);
			lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 600) : int'(sp) * 512 + 256;
			cur = random_pt();
			for (k = 0; k < len; k++) begin
				if (k > 0)
					cur = ($urandom_range(0, 11) == 0) ? random_pt() : walk_pt(cur, lim);
				send_point(cur, k == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		logic [15:0] sp;
		int          ph;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Spacing zero: every point passes the distance test.
		write_spacing(16'd0);
		send_point(make_pt(C_MAX, C_MAX, C_MAX), 1'b1);  // lone final point, out twice
		send_point(make_pt(C_MIN, C_MIN, C_MIN), 1'b0);
		send_point(make_pt(C_MAX, C_MAX, C_MAX), 1'b0);
		send_point(make_pt(0, 0, 0), 1'b1);
		drain();

		// Widest spacing.
		write_spacing(16'hFFFF);
		// nothing beyond the first kept, final close: first and final come out
		send_point(make_pt(0, 0, 0), 1'b0);
		send_point(make_pt(1, -2, 3), 1'b0);
		send_point(make_pt(-5, 7, 0), 1'b1);
		// a far point kept, final close to it: held point closes the run
		send_point(make_pt(C_MIN, C_MIN, C_MIN), 1'b0);
		send_point(make_pt(C_MAX, C_MAX, C_MAX), 1'b0);
		send_point(make_pt(C_MAX - 1, C_MAX, C_MAX), 1'b1);
		// final point itself far enough: dropped, first point closes the run
		send_point(make_pt(C_MIN, 0, 0), 1'b0);
		send_point(make_pt(C_MAX, 0, 0), 1'b1);
		drain();

		// One unit: the threshold sits at exactly half a unit (128 raw).
		write_spacing(16'd1);
		send_point(make_pt(0, 0, 0), 1'b0);
		send_point(make_pt(128, 0, 0), 1'b0);     // exactly on the threshold: kept
		send_point(make_pt(255, 0, 0), 1'b0);     // one raw unit short: skipped
		send_point(make_pt(128, 0, -127), 1'b1);  // final not kept, earlier point kept
		send_point(make_pt(-1, -1, -1), 1'b0);
		send_point(make_pt(-1, -1, 126), 1'b1);   // final short of the threshold, only first kept
		drain();

		// Random phases through several spacings, extremes among them.
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: sp = 16'd0;
				1: sp = 16'd1;
				2: sp = 16'hFFFF;
				3: sp = 16'($urandom_range(2, 40));
				4: sp = 16'($urandom);
				default: sp = 16'd3;
			endcase
			write_spacing(sp);
			if (ph == 1) begin
				// long receiver hold-off while points keep coming back to back
				holds_asked++;
				burst_left = 80;
			end
			run_random_phase(180, sp);
			drain();
		end

		if (pending != 0)
			$display("%0d expected items never arrived", pending);
		if (mismatches == 0 && pending == 0) begin
			$display("[polyline_distance_decimator] OK");
		end else begin
			$display("[polyline_distance_decimator] ERROR");
		end
		$finish;
	end

endmodule

### polyline_distance_decimator.f
+incdir+design
design/pld_pkg.sv
design/pld_dist.sv
design/pld_oq.sv
design/polyline_distance_decimator.sv
design/pld_checker.sv
bench/pld_stream_checker.sv
bench/polyline_distance_decimator_test.sv
